// ----- sv/dbts_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile store package
// Widths, defaults and the memory entry layout shared by the tile store
// top level and its memory.
// ----------------------------------------------------------------------------
package dbts_pkg;

	localparam int WORDS_PER_BANK_DEF = 1024;
	localparam int TAG_BITS_DEF       = 8;

	localparam int ADDR_W  = 10;
	localparam int DATA_W  = 64;
	localparam int TAG_W   = 8;
	localparam int CNT_W   = 32;
	localparam int EPOCH_W = 12;
	localparam int IN_W    = 176;
	localparam int OUT_W   = 176;

	localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Epoch zero is reserved: an entry marked with it is never present.
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [DATA_W-1:0]  word;
	} entry_t;

endpackage

// ----- sv/dbts_mem.sv -----
// ----------------------------------------------------------------------------
// Tile store memory
// Both banks in one synchronous memory: two registered read ports and one
// write port. A read and a write of the same entry in one cycle read old data.
// ----------------------------------------------------------------------------
module dbts_mem #(
	parameter int ADDR_BITS = $clog2(dbts_pkg::WORDS_PER_BANK_DEF) + 1
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr_a,
	input  logic [ADDR_BITS-1:0] rd_addr_b,
	output dbts_pkg::entry_t     rd_entry_a,
	output dbts_pkg::entry_t     rd_entry_b,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  dbts_pkg::entry_t     wr_entry
);

	localparam int DEPTH = 1 << ADDR_BITS;

	dbts_pkg::entry_t mem [DEPTH];
	dbts_pkg::entry_t rd_entry_a_q;
	dbts_pkg::entry_t rd_entry_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_a_q <= mem[rd_addr_a];
			rd_entry_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_entry_a = rd_entry_a_q;
	assign rd_entry_b = rd_entry_b_q;

endmodule

// ----- sv/double_buffered_fast_clear_tile_store_unit.sv -----
// ----------------------------------------------------------------------------
// Double-buffered tile store with fast clear
// Two banks of 64-bit words with a per-bank clear word. A clear bumps the
// bank's epoch instead of touching every word; a word is present when its
// stored epoch matches the bank's epoch.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload (tdata, lowest bit first)
// s_axis    in         one cycle of write, read, resolve, clear and swap commands
// m_axis    out        write_ready, read and resolve answers, bank select, count
//
// A transaction is taken every cycle while the output drains and no sweep runs;
// its result is read from the memory's registered ports into the read stage and
// then registered in the output stage. After reset a sweep marks every entry of
// both banks empty, with s_axis_tready low until it ends.
// When a bank's epoch runs out (once every 4095 clears of that bank) a sweep of
// that bank's entries stalls the input.
// A stalled m_axis holds its result, one more in the read stage, then input.
//
module double_buffered_fast_clear_tile_store_unit #(
	parameter int WORDS_PER_BANK = dbts_pkg::WORDS_PER_BANK_DEF,
	parameter int TAG_BITS       = dbts_pkg::TAG_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// write_req, write_addr, write_data, read_req, read_addr, read_tag,
	// resolve_req, resolve_addr, clear_req, clear_word, swap_req, zero pad
	input  logic [dbts_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// write_ready, read_valid, read_data, read_tag_out, resolve_valid,
	// resolve_data, front_is_bank1, access_count, zero pad
	output logic [dbts_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int AW = (WORDS_PER_BANK > 1) ? $clog2(WORDS_PER_BANK) : 1;
	localparam int MA = AW + 1;
	localparam int PAD_W = dbts_pkg::OUT_W - (3 * 1 + 2 * dbts_pkg::DATA_W
		+ dbts_pkg::TAG_W + 1 + dbts_pkg::CNT_W);
	localparam logic [dbts_pkg::TAG_W-1:0] TAG_MASK =
		dbts_pkg::TAG_W'((33'd1 << TAG_BITS) - 33'd1);

	// Remainder by the bank size through a chain of compare and subtract.
	function automatic logic [AW-1:0] wrap_addr(input logic [dbts_pkg::ADDR_W-1:0] a);
		logic [dbts_pkg::ADDR_W-1:0] v;
		v = a;
		for (int k = dbts_pkg::ADDR_W - 1; k >= 0; k--) begin
			if (33'(v) >= (33'(WORDS_PER_BANK) << k)) begin
				v = v - dbts_pkg::ADDR_W'(33'(WORDS_PER_BANK) << k);
			end
		end
		return AW'(v);
	endfunction

	// Input fields
	logic                        in_wr;
	logic [AW-1:0]               in_wa;
	logic [dbts_pkg::DATA_W-1:0] in_wd;
	logic                        in_rd;
	logic [AW-1:0]               in_ra;
	logic [dbts_pkg::TAG_W-1:0]  in_tag;
	logic                        in_rs;
	logic [AW-1:0]               in_sa;
	logic                        in_clr;
	logic [dbts_pkg::DATA_W-1:0] in_cw;
	logic                        in_sw;

	assign in_wr  = s_axis_tdata[0];
	assign in_wa  = wrap_addr(s_axis_tdata[10:1]);
	assign in_wd  = s_axis_tdata[74:11];
	assign in_rd  = s_axis_tdata[75];
	assign in_ra  = wrap_addr(s_axis_tdata[85:76]);
	assign in_tag = s_axis_tdata[93:86];
	assign in_rs  = s_axis_tdata[94];
	assign in_sa  = wrap_addr(s_axis_tdata[104:95]);
	assign in_clr = s_axis_tdata[105];
	assign in_cw  = s_axis_tdata[169:106];
	assign in_sw  = s_axis_tdata[170];

	// State
	logic                         front_q;
	logic [dbts_pkg::EPOCH_W-1:0] epoch_q [2];
	logic [dbts_pkg::DATA_W-1:0]  fill_word_q [2];
	logic [dbts_pkg::CNT_W-1:0]   count_q;

	logic          sweep_q;
	logic          sweep_both_q;
	logic          sweep_bank_q;
	logic [AW-1:0] sweep_idx_q;

	// Read stage
	logic                         valid_s1;
	logic                         clr_s1;
	logic                         fwd_s1;
	logic [dbts_pkg::DATA_W-1:0]  wd_s1;
	logic                         rd_s1;
	logic [dbts_pkg::TAG_W-1:0]   tag_s1;
	logic                         rs_s1;
	logic [dbts_pkg::EPOCH_W-1:0] front_epoch_s1;
	logic [dbts_pkg::EPOCH_W-1:0] back_epoch_s1;
	logic [dbts_pkg::DATA_W-1:0]  front_cw_s1;
	logic [dbts_pkg::DATA_W-1:0]  back_cw_s1;
	logic                         front_bank1_s1;
	logic [dbts_pkg::CNT_W-1:0]   count_s1;

	logic                       out_valid_q;
	logic [dbts_pkg::OUT_W-1:0] out_data_q;

	logic back_sel;
	logic advance;
	logic accept;
	logic wr_acc;
	logic [1:0] add;
	logic [dbts_pkg::CNT_W:0] sum;
	logic [dbts_pkg::CNT_W-1:0] count_next;

	dbts_pkg::entry_t rd_entry_a;
	dbts_pkg::entry_t rd_entry_b;
	logic             mem_wr_en;
	logic [MA-1:0]    mem_wr_addr;
	dbts_pkg::entry_t mem_wr_entry;

	assign back_sel      = ~front_q;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !sweep_q && (!valid_s1 || advance);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr_acc        = in_wr && !in_clr;

	assign add        = {1'b0, wr_acc} + {1'b0, in_rd} + {1'b0, in_rs};
	assign sum        = {1'b0, count_q} + (dbts_pkg::CNT_W + 1)'(add);
	assign count_next = sum[dbts_pkg::CNT_W] ? dbts_pkg::COUNT_MAX : sum[dbts_pkg::CNT_W-1:0];

	always_comb begin
		mem_wr_en    = 1'b0;
		mem_wr_addr  = {front_q, in_wa};
		mem_wr_entry = '{epoch: epoch_q[front_q], word: in_wd};
		if (sweep_q) begin
			mem_wr_en    = 1'b1;
			mem_wr_addr  = {sweep_bank_q, sweep_idx_q};
			mem_wr_entry = '{epoch: dbts_pkg::EPOCH_NONE, word: in_wd};
		end else if (accept && wr_acc) begin
			mem_wr_en = 1'b1;
		end
	end

	dbts_mem #(
		.ADDR_BITS(MA)
	) u_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a ({front_q, in_ra}),
		.rd_addr_b ({back_sel, in_sa}),
		.rd_entry_a(rd_entry_a),
		.rd_entry_b(rd_entry_b),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_entry  (mem_wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q        <= 1'b0;
			epoch_q[0]     <= dbts_pkg::EPOCH_FIRST;
			epoch_q[1]     <= dbts_pkg::EPOCH_FIRST;
			fill_word_q[0] <= '0;
			fill_word_q[1] <= '0;
			count_q        <= '0;
			sweep_q        <= 1'b1;
			sweep_both_q   <= 1'b1;
			sweep_bank_q   <= 1'b0;
			sweep_idx_q    <= '0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (sweep_q) begin
				sweep_idx_q <= sweep_idx_q + AW'(1);
				if (&sweep_idx_q) begin
					if (sweep_both_q && !sweep_bank_q) begin
						sweep_bank_q <= 1'b1;
					end else begin
						sweep_q      <= 1'b0;
						sweep_both_q <= 1'b0;
					end
				end
			end
			if (accept) begin
				front_q <= front_q ^ in_sw;
				count_q <= count_next;
				if (in_clr) begin
					fill_word_q[front_q] <= in_cw;
					// Out of epochs: mark the bank empty by a sweep, then restart.
					if (epoch_q[front_q] == dbts_pkg::EPOCH_LAST) begin
						epoch_q[front_q] <= dbts_pkg::EPOCH_FIRST;
						sweep_q          <= 1'b1;
						sweep_both_q     <= 1'b0;
						sweep_bank_q     <= front_q;
						sweep_idx_q      <= '0;
					end else begin
						epoch_q[front_q] <= epoch_q[front_q] + dbts_pkg::EPOCH_W'(1);
					end
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clr_s1         <= in_clr;
			fwd_s1         <= wr_acc && (in_wa == in_ra);
			wd_s1          <= in_wd;
			rd_s1          <= in_rd;
			tag_s1         <= in_tag & TAG_MASK;
			rs_s1          <= in_rs;
			front_epoch_s1 <= epoch_q[front_q];
			back_epoch_s1  <= epoch_q[back_sel];
			front_cw_s1    <= in_clr ? in_cw : fill_word_q[front_q];
			back_cw_s1     <= fill_word_q[back_sel];
			front_bank1_s1 <= front_q ^ in_sw;
			count_s1       <= count_next;
		end
	end

	logic                        front_hit;
	logic                        back_hit;
	logic [dbts_pkg::DATA_W-1:0] read_data;
	logic [dbts_pkg::DATA_W-1:0] resolve_data;
	logic [dbts_pkg::TAG_W-1:0]  read_tag_out;

	always_comb begin
		front_hit    = !clr_s1 && (rd_entry_a.epoch == front_epoch_s1);
		back_hit     = rd_entry_b.epoch == back_epoch_s1;
		read_data    = '0;
		read_tag_out = '0;
		resolve_data = '0;
		if (rd_s1) begin
			read_tag_out = tag_s1;
			if (fwd_s1) begin
				read_data = wd_s1;
			end else if (front_hit) begin
				read_data = rd_entry_a.word;
			end else begin
				read_data = front_cw_s1;
			end
		end
		if (rs_s1) begin
			resolve_data = back_hit ? rd_entry_b.word : back_cw_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {{PAD_W{1'b0}}, count_s1, front_bank1_s1, resolve_data, rs_s1,
				read_tag_out, read_data, rd_s1, !clr_s1};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
